/* hw/rtl/ut8d_pkg.sv */
// Shared types and constants of the UTF-8 validating decoder.
package ut8d_pkg;

  // Field widths
  localparam int CP_W      = 21;
  localparam int USED_W    = 3;
  localparam int MAX_RES   = 3;
  localparam int CNT_W     = 2;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_REPL = 1'b0;

  // Reset value of the replacement code point
  localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

  // Byte classes and second-byte limits
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_MIN      = 8'hA0;
  localparam logic [7:0] ED_MAX      = 8'h9F;
  localparam logic [7:0] F0_MIN      = 8'h90;
  localparam logic [7:0] F4_MAX      = 8'h8F;
  localparam logic [7:0] CONT_BITS   = 8'h3F;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD4_BITS  = 8'h07;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic              bad;
    logic [USED_W-1:0] used;
  } res_t;

  // Decoder state
  typedef struct packed {
    logic [2:0]      exp_len;
    logic [1:0]      seen;
    logic [7:0]      lead;
    logic [CP_W-1:0] part;
    logic            stray;
  } dec_state_t;

  // Handshake between the result queue and the input stage
  typedef struct packed {
    logic free;
    logic load;
  } q_ctrl_t;

endpackage

/* hw/rtl/utf8_validating_decoder.sv */
// Top level of the UTF-8 validating decoder.
//
//  channel | direction | tdata                              | tuser       | tlast
//  in_     | slave     | [7:0] data_byte                    | -           | end_of_buffer
//  out_    | master    | [20:0] code_point, [23:21] used    | was_invalid | last_result
//  cfg_    | APB       | 0x0: replacement_value [20:0]      | -           | -
//
// A byte passes from the input register through the decode logic into the
// result queue once it is free. Bytes with at most one result pass at one
// per cycle while the output is not stalled; a byte with more results holds
// the input until the single result port drains the queue to its last result.
// rst_n clears decoder state and the queue and sets the replacement value to
// U+FFFD. A stalled output holds the queue head and, once full, the input register.
module utf8_validating_decoder import ut8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] bytes_used
  output logic        out_tuser,  // [0] was_invalid
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;
  logic             in_eob_r;
  logic [CP_W-1:0]  repl_r;
  q_ctrl_t          qc;
  res_t             dec_res [MAX_RES];
  logic [CNT_W-1:0] dec_cnt;
  res_t             head;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_REPL) ? {{(32-CP_W){1'b0}}, repl_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_REPL) begin
      repl_r <= cfg_pwdata[CP_W-1:0];
    end
  end

  // Input register: decode when the queue can take the results
  assign qc.load   = in_vld_r && qc.free;
  assign in_tready = !in_vld_r || qc.load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (qc.load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eob_r  <= in_tlast;
    end
  end

  ut8d_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (qc.load),
    .byte_i (in_byte_r),
    .eob_i  (in_eob_r),
    .repl_i (repl_r),
    .res_o  (dec_res),
    .cnt_o  (dec_cnt)
  );

  ut8d_res_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (qc.load),
    .res_i   (dec_res),
    .cnt_i   (dec_cnt),
    .ready_i (out_tready),
    .valid_o (out_tvalid),
    .res_o   (head),
    .last_o  (out_tlast),
    .free_o  (qc.free)
  );

  // Pack the result
  assign out_tdata = {head.used, head.cp};
  assign out_tuser = head.bad;

endmodule

/* hw/rtl/ut8d_decode.sv */
// Per-byte decode logic and decoder state register.
module ut8d_decode import ut8d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            eob_i,
  input  logic [CP_W-1:0] repl_i,
  output res_t            res_o [MAX_RES],
  output logic [CNT_W-1:0] cnt_o
);

  dec_state_t st_r;
  dec_state_t st_nxt;

  always_comb begin
    dec_state_t  s;
    logic [CNT_W-1:0] k;
    logic        cont;
    logic        ok;
    logic        fresh;
    logic [2:0]  seen_inc;
    res_t        bad_res;

    s        = st_r;
    k        = '0;
    cont     = (byte_i & CONT_MASK) == CONT_TAG;
    ok       = 1'b1;
    fresh    = 1'b0;
    seen_inc = {1'b0, st_r.seen} + 3'd1;
    bad_res  = '{cp: repl_i, bad: 1'b1, used: USED_W'(1)};
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = bad_res;
    end

    if (st_r.exp_len != 3'd0) begin
      if (!cont) begin
        // Cut short: replace the lead, and the taken continuations as a stray run
        res_o[k] = bad_res;
        k = k + 2'd1;
        if (st_r.seen > 2'd1) begin
          res_o[k] = bad_res;
          k = k + 2'd1;
        end
        s.exp_len = '0;
        s.seen    = '0;
        s.lead    = '0;
        s.part    = '0;
        fresh     = 1'b1;
      end else begin
        // Check the second-byte limits
        if (st_r.seen == 2'd1) begin
          if (st_r.lead == LEAD_E0 && byte_i < E0_MIN) ok = 1'b0;
          if (st_r.lead == LEAD_ED && byte_i > ED_MAX) ok = 1'b0;
          if (st_r.lead == LEAD_F0 && byte_i < F0_MIN) ok = 1'b0;
          if (st_r.lead == LEAD_F4 && byte_i > F4_MAX) ok = 1'b0;
        end
        if (!ok) begin
          res_o[k] = bad_res;
          k = k + 2'd1;
          res_o[k] = bad_res;
          k = k + 2'd1;
          s.exp_len = '0;
          s.seen    = '0;
          s.lead    = '0;
          s.part    = '0;
          s.stray   = 1'b1;
        end else begin
          // Gather six more bits
          s.part = {st_r.part[CP_W-7:0], byte_i[5:0] & CONT_BITS[5:0]};
          s.seen = seen_inc[1:0];
          if (seen_inc >= st_r.exp_len) begin
            res_o[k] = '{cp: s.part, bad: 1'b0, used: st_r.exp_len};
            k = k + 2'd1;
            s.exp_len = '0;
            s.seen    = '0;
            s.lead    = '0;
            s.part    = '0;
            s.stray   = 1'b0;
          end
        end
      end
    end else begin
      fresh = 1'b1;
    end

    // Decode a byte with no sequence pending
    if (fresh) begin
      if (cont) begin
        if (!s.stray) begin
          res_o[k] = bad_res;
          k = k + 2'd1;
        end
        s.stray = 1'b1;
      end else begin
        s.stray = 1'b0;
        if (byte_i < ASCII_END) begin
          res_o[k] = '{cp: CP_W'(byte_i), bad: 1'b0, used: USED_W'(1)};
          k = k + 2'd1;
        end else if (byte_i >= LEAD2_MIN && byte_i <= LEAD2_MAX) begin
          s.exp_len = 3'd2;
          s.part    = CP_W'(byte_i & LEAD2_BITS);
          s.seen    = 2'd1;
          s.lead    = byte_i;
        end else if (byte_i >= LEAD3_MIN && byte_i <= LEAD3_MAX) begin
          s.exp_len = 3'd3;
          s.part    = CP_W'(byte_i & LEAD3_BITS);
          s.seen    = 2'd1;
          s.lead    = byte_i;
        end else if (byte_i >= LEAD4_MIN && byte_i <= LEAD4_MAX) begin
          s.exp_len = 3'd4;
          s.part    = CP_W'(byte_i & LEAD4_BITS);
          s.seen    = 2'd1;
          s.lead    = byte_i;
        end else begin
          res_o[k] = bad_res;
          k = k + 2'd1;
        end
      end
    end

    // Flush a pending sequence at the end of the buffer
    if (eob_i) begin
      if (s.exp_len != 3'd0) begin
        res_o[k] = bad_res;
        k = k + 2'd1;
        if (s.seen > 2'd1) begin
          res_o[k] = bad_res;
          k = k + 2'd1;
        end
      end
      s = '0;
    end

    st_nxt = s;
    cnt_o  = k;
  end

  // Hold state, advance on each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_i) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* hw/rtl/ut8d_res_queue.sv */
// Result queue: holds one byte's results and sends one per cycle while ready.
module ut8d_res_queue import ut8d_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_i,
  input  res_t             res_i [MAX_RES],
  input  logic [CNT_W-1:0] cnt_i,
  input  logic             ready_i,
  output logic             valid_o,
  output res_t             res_o,
  output logic             last_o,
  output logic             free_o
);

  res_t             slot_r [MAX_RES];
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] hd_r;
  logic             pop;

  assign valid_o = rem_r != '0;
  assign pop     = valid_o && ready_i;
  assign last_o  = rem_r == CNT_W'(1);
  assign free_o  = (rem_r == '0) || (last_o && pop);

  // Select the head slot
  always_comb begin
    case (hd_r)
      2'd0:    res_o = slot_r[0];
      2'd1:    res_o = slot_r[1];
      2'd2:    res_o = slot_r[2];
      default: res_o = slot_r[0];
    endcase
  end

  // Load a new set, or drop the head on each taken request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      hd_r  <= '0;
    end else if (load_i) begin
      rem_r <= cnt_i;
      hd_r  <= '0;
    end else if (pop) begin
      rem_r <= rem_r - CNT_W'(1);
      hd_r  <= hd_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slot_r[i] <= res_i[i];
      end
    end
  end

endmodule

/* verif/utf8_stream_checker.sv */
// Checker for the UTF-8 decoder: snoops both streams and the APB port, predicts and compares.
`timescale 1ns / 100ps

module utf8_stream_checker import ut8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [20:0] code_point, [23:21] bytes_used
  input  logic        out_tuser,  // [0] was_invalid
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          waiting,
  output int          results_checked,
  output int          repl_count
);

  localparam int MAX_PRINTS = 20;

  // One predicted or observed code point
  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic              bad;
    logic [USED_W-1:0] used;
    logic              last;
  } code_point_t;

  // Predicted decoder state and the replacement register
  logic [2:0]      seq_len;
  logic [2:0]      seq_taken;
  logic [7:0]      seq_lead;
  logic [CP_W-1:0] seq_bits;
  logic            in_stray;
  logic [CP_W-1:0] repl_cp;

  code_point_t step_cps[$];
  code_point_t expected_cps[$];

  initial begin
    fail_count      = 0;
    waiting         = 0;
    results_checked = 0;
    repl_count      = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic add_cp(input logic [CP_W-1:0] cp, input logic bad,
                        input logic [USED_W-1:0] used);
    code_point_t r;
    r.cp   = cp;
    r.bad  = bad;
    r.used = used;
    r.last = 1'b0;
    step_cps.push_back(r);
  endtask

  task automatic add_repl();
    add_cp(repl_cp, 1'b1, 3'd1);
  endtask

  task automatic clear_seq();
    seq_len   = '0;
    seq_taken = '0;
    seq_lead  = '0;
    seq_bits  = '0;
  endtask

  // Cut-short sequence: one replacement for the lead, one for taken continuations
  task automatic flush_seq();
    add_repl();
    if (seq_taken > 1) add_repl();
    clear_seq();
  endtask

  task automatic open_seq(input logic [2:0] len, input logic [7:0] b, input logic [7:0] bits);
    seq_len   = len;
    seq_taken = 3'd1;
    seq_lead  = b;
    seq_bits  = {{(CP_W-8){1'b0}}, b & bits};
  endtask

  // Decode a byte with no sequence pending
  task automatic start_byte(input logic [7:0] b);
    if ((b & CONT_MASK) == CONT_TAG) begin
      if (!in_stray) add_repl();
      in_stray = 1'b1;
    end else begin
      in_stray = 1'b0;
      if (b < ASCII_END) add_cp({{(CP_W-8){1'b0}}, b}, 1'b0, 3'd1);
      else if (b >= LEAD2_MIN && b <= LEAD2_MAX) open_seq(3'd2, b, LEAD2_BITS);
      else if (b >= LEAD3_MIN && b <= LEAD3_MAX) open_seq(3'd3, b, LEAD3_BITS);
      else if (b >= LEAD4_MIN && b <= LEAD4_MAX) open_seq(3'd4, b, LEAD4_BITS);
      else add_repl();
    end
  endtask

  // Predict the code points caused by one input request
  task automatic decode_byte(input logic [7:0] b, input logic eob);
    logic        ok;
    code_point_t r;
    step_cps.delete();
    if (seq_len != 0) begin
      if ((b & CONT_MASK) != CONT_TAG) begin
        flush_seq();
        start_byte(b);
      end else begin
        ok = 1'b1;
        if (seq_taken == 3'd1) begin
          if (seq_lead == LEAD_E0 && b < E0_MIN) ok = 1'b0;
          if (seq_lead == LEAD_ED && b > ED_MAX) ok = 1'b0;
          if (seq_lead == LEAD_F0 && b < F0_MIN) ok = 1'b0;
          if (seq_lead == LEAD_F4 && b > F4_MAX) ok = 1'b0;
        end
        if (!ok) begin
          add_repl();
          add_repl();
          clear_seq();
          in_stray = 1'b1;
        end else begin
          seq_bits  = {seq_bits[CP_W-7:0], b[5:0]};
          seq_taken = seq_taken + 3'd1;
          if (seq_taken >= seq_len) begin
            add_cp(seq_bits, 1'b0, seq_len);
            clear_seq();
            in_stray = 1'b0;
          end
        end
      end
    end else begin
      start_byte(b);
    end
    // End of buffer: flush and return to the idle state
    if (eob) begin
      if (seq_len != 0) flush_seq();
      clear_seq();
      in_stray = 1'b0;
    end
    foreach (step_cps[i]) begin
      r = step_cps[i];
      r.last = (i == step_cps.size() - 1);
      expected_cps.push_back(r);
    end
  endtask

  // Compare one output request with the oldest prediction
  task automatic check_result();
    code_point_t got;
    code_point_t exp_cp;
    got.cp   = out_tdata[CP_W-1:0];
    got.used = out_tdata[CP_W+USED_W-1:CP_W];
    got.bad  = out_tuser;
    got.last = out_tlast;
    if (expected_cps.size() == 0) begin
      report_mismatch($sformatf("unexpected result cp=%h bad=%b used=%0d last=%b",
                                got.cp, got.bad, got.used, got.last));
    end else begin
      exp_cp = expected_cps.pop_front();
      results_checked++;
      if (exp_cp.bad) repl_count++;
      if (got.cp !== exp_cp.cp || got.bad !== exp_cp.bad ||
          got.used !== exp_cp.used || got.last !== exp_cp.last)
        report_mismatch($sformatf("cp %h/%h bad %b/%b used %0d/%0d last %b/%b (got/exp)",
                                  got.cp, exp_cp.cp, got.bad, exp_cp.bad,
                                  got.used, exp_cp.used, got.last, exp_cp.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_seq();
      in_stray = 1'b0;
      repl_cp  = REPL_RESET;
      expected_cps.delete();
      waiting <= 0;
    end else begin
      // Track register writes and check register reads
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_REPL) begin
        if (cfg_pwrite)
          repl_cp = cfg_pwdata[CP_W-1:0];
        else if (cfg_prdata !== {{(32-CP_W){1'b0}}, repl_cp})
          report_mismatch($sformatf("register read %h, expected %h", cfg_prdata, repl_cp));
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
      waiting <= expected_cps.size();
    end
  end

endmodule

/* verif/tb_utf8_validating_decoder.sv */
// Testbench top for the UTF-8 validating decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_utf8_validating_decoder import ut8d_pkg::*; ();

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          HOLD_CYCLES   = 80;
  localparam logic [2:0]  REPL_ADDR     = {REG_REPL, 2'b00};
  localparam logic [2:0]  SPARE_ADDR    = {~REG_REPL, 2'b00};
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [20:0] code_point, [23:21] bytes_used
  logic        out_tuser;        // [0] was_invalid
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int waiting;
  int results_checked;
  int repl_count;
  int cycles = 0;
  int bytes_sent = 0;
  int repl_settings = 1;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  logic [7:0] char_bytes[$];
  logic [8:0] directed[$];

  utf8_validating_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  utf8_stream_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .waiting         (waiting),
    .results_checked (results_checked),
    .repl_count      (repl_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** utf8_validating_decoder: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // Offer one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eob;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drain all outstanding results, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Set a new replacement value and read it back
  task automatic set_repl(input logic [31:0] value);
    apb_access(1'b1, REPL_ADDR, value);
    apb_access(1'b0, REPL_ADDR, '0);
    repl_settings++;
  endtask

  // Build one character: mostly well-formed, some truncated, corrupt, stray or noise
  task automatic make_char();
    int         pick;
    int         len;
    int         keep;
    bit         corrupt;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    char_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      char_bytes.push_back(8'($urandom_range(255)));
    end else if (pick < 13) begin
      repeat ($urandom_range(1, 3))
        char_bytes.push_back(8'($urandom_range(CONT_TAG, CONT_TAG | CONT_BITS)));
    end else begin
      len = $urandom_range(1, 4);
      keep = len;
      corrupt = 1'b0;
      if (len > 1 && pick < 25) begin
        if ($urandom_range(1)) keep = $urandom_range(1, len - 1);
        else corrupt = 1'b1;
      end
      case (len)
        1: lead = 8'($urandom_range(0, ASCII_END - 1));
        2: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
        3: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
        default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
      endcase
      // Second-byte window that keeps the sequence legal
      lo = CONT_TAG;
      hi = CONT_TAG | CONT_BITS;
      if (lead == LEAD_E0) lo = E0_MIN;
      if (lead == LEAD_ED) hi = ED_MAX;
      if (lead == LEAD_F0) lo = F0_MIN;
      if (lead == LEAD_F4) hi = F4_MAX;
      char_bytes.push_back(lead);
      if (keep > 1)
        char_bytes.push_back(corrupt ? 8'($urandom_range(255)) : 8'($urandom_range(lo, hi)));
      for (int i = 2; i < keep; i++)
        char_bytes.push_back(8'($urandom_range(CONT_TAG, CONT_TAG | CONT_BITS)));
    end
  endtask

  task automatic send_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      make_char();
      foreach (char_bytes[i]) begin
        send_byte(char_bytes[i], $urandom_range(99) < 4);
        sent++;
      end
    end
  endtask

  initial begin
    // Directed bytes, end-of-buffer flag in bit 8
    directed = '{
      9'h000, 9'h07F,                     // NUL and top of ASCII
      9'h0C2, 9'h080,                     // lowest 2-byte
      9'h0E0, 9'h0A0, 9'h080,             // lowest 3-byte after E0
      9'h0ED, 9'h09F, 9'h0BF,             // last value below surrogates
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,     // highest code point
      9'h0ED, 9'h0A0, 9'h0BF,             // surrogate limit, stray run continues
      9'h0C0, 9'h0FF,                     // invalid leads
      9'h0E2, 9'h082, 9'h041,             // breaking byte after a continuation
      9'h0F0, 9'h08F,                     // overlong limit after F0
      9'h0F0, 9'h190,                     // end of buffer mid-sequence
      9'h180                              // stray byte opening a new buffer
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset value, directed cases, then random traffic
    apb_access(1'b0, REPL_ADDR, '0);
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    send_random(60);
    settle();

    set_repl('0);
    send_random(64);
    settle();

    // Highest value, with a long result-side hold-off to back up the input
    set_repl({{(32-CP_W){1'b0}}, CP_MAX});
    hold_req = 1'b1;
    send_random(64);
    settle();

    // Upper bits dropped, spare address ignored, no idling on either side
    set_repl($urandom);
    apb_access(1'b1, SPARE_ADDR, $urandom);
    apb_access(1'b0, REPL_ADDR, '0);
    calm = 1'b1;
    send_random(64);
    settle();
    calm = 1'b0;

    set_repl({{(32-CP_W){1'b0}}, REPL_RESET});
    send_random(68);
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d code points (%0d replacements)",
             bytes_sent, results_checked, repl_count);
    $display("across %0d replacement settings, with one long output hold-off",
             repl_settings);
    if (fail_count == 0 && waiting == 0) begin
      $display("** utf8_validating_decoder: PASSED **");
    end else begin
      $display("** utf8_validating_decoder: FAILED **");
    end
    $finish;
  end

endmodule
